// ===== sv/wmj_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the waypoint minimum-jerk trajectory block.
// Depends on nothing; imported by the top level.
package wmj_pkg;

    localparam int SEG_DEPTH = 64;
    localparam int SEG_AW    = $clog2(SEG_DEPTH);
    localparam int SEG_CW    = $clog2(SEG_DEPTH + 1);

    // 1.0 in Q28
    localparam logic [28:0] TAU_ONE = 29'h1000_0000;
    // acceleration clamp on the first quotient, 2^47
    localparam logic signed [63:0] ACC_LIM = 64'sh0000_8000_0000_0000;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_EVAL   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_APPEND,
        S_HOLD,
        S_RD,
        S_CMP,
        S_TAU,
        S_TDIV,
        S_MUL,
        S_MULW,
        S_POLY,
        S_AXP,
        S_AXPW,
        S_AXV,
        S_AXVW,
        S_VDIV,
        S_AXA,
        S_AXAW,
        S_A1DIV,
        S_A2DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0]      t_beg;
        logic [31:0]      t_fin;
        logic             is_move;
        logic [2:0][31:0] origin;
        logic [2:0][32:0] delta;
    } seg_entry_t;

    localparam int SEG_W = $bits(seg_entry_t);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/wmj_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wmj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== sv/waypoint_min_jerk_trajectory.sv =====
`timescale 1ns / 1ps
// Append runs S_APPEND then S_HOLD (S_APPEND alone when dropped) before the result strobe;
// clear, no-op and evaluate on an empty table go straight to it. Evaluate reads and compares
// one segment at a time; a hold ends there, a move then runs tau, its powers and the shared
// 64-step divider; the tau divide goes when not needed, the second acceleration one on a clamp.
// Throughput: one transaction at a time; busy stays high until the result strobe has gone.
// Reset: asynchronous, active low; empties the segment table, cursor and waypoint history.
// The receiver cannot stall: each result shows for one cycle with strobe.
// Depends on wmj_pkg and wmj_ram.
module waypoint_min_jerk_trajectory
    import wmj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [31:0]        sample_time,
    input  logic signed [31:0] way_x,
    input  logic signed [31:0] way_y,
    input  logic signed [31:0] way_z,
    input  logic [31:0]        arrive_time,
    input  logic [31:0]        dwell_time,
    output logic               strobe,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    output logic signed [31:0] out_acc_x,
    output logic signed [31:0] out_acc_y,
    output logic signed [31:0] out_acc_z,
    output logic               done_flag,
    output logic               status
);

    // ------------------------------------------------------------------
    // Control state (reset)
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [SEG_CW-1:0]  seg_used_reg;
    logic               way_seen_reg;
    logic [31:0]        cursor_reg;
    logic signed [31:0] prev_reg  [3];
    logic signed [31:0] first_reg [3];
    logic [SEG_AW-1:0]  idx_reg;
    logic [1:0]         step_reg;
    logic [1:0]         axis_reg;
    logic [5:0]         dv_cnt_reg;

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    logic [31:0]        t_reg;
    logic [31:0]        arrive_reg;
    logic [31:0]        dwell_reg;
    logic signed [31:0] pt_reg [3];
    logic [28:0]        tau_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [33:0] s_reg, s1_reg, s2_reg;
    logic signed [67:0] prod_reg;
    logic [31:0]        dv_rem_reg;
    logic [63:0]        dv_num_reg;
    logic               dv_neg_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] acc_reg [3];
    logic               done_reg;
    logic               status_reg;

    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign strobe = (state_reg == S_OUT);

    // ------------------------------------------------------------------
    // Segment table: one RAM word per segment
    // ------------------------------------------------------------------
    logic             ram_we, ram_re;
    logic [SEG_W-1:0] ram_rdata;
    seg_entry_t       rd_ent, wr_ent;

    assign rd_ent = ram_rdata;
    assign ram_re = (state_reg == S_RD);

    // Append decision: a move needs a prior waypoint and a later arrival.
    logic              move_add, hold_add, drop;
    logic [1:0]        need;
    logic [32:0]       hold_sum;
    logic [31:0]       hold_end;

    assign move_add = way_seen_reg && (arrive_reg > cursor_reg);
    assign hold_add = (dwell_reg != 32'd0);
    assign need     = {1'b0, move_add} + {1'b0, hold_add};
    assign drop     = ({1'b0, seg_used_reg} + (SEG_CW + 1)'(need)) > (SEG_CW + 1)'(SEG_DEPTH);
    assign hold_sum = {1'b0, cursor_reg} + {1'b0, dwell_reg};
    // Saturate the hold end at the top of the time range.
    assign hold_end = hold_sum[32] ? 32'hFFFF_FFFF : hold_sum[31:0];

    always_comb
    begin
        wr_ent.t_beg = cursor_reg;
        if (state_reg == S_APPEND)
        begin
            wr_ent.t_fin   = arrive_reg;
            wr_ent.is_move = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                wr_ent.origin[a] = prev_reg[a];
                wr_ent.delta[a]  = {pt_reg[a][31], pt_reg[a]} - {prev_reg[a][31], prev_reg[a]};
            end
        end
        else
        begin
            wr_ent.t_fin   = hold_end;
            wr_ent.is_move = 1'b0;
            for (int a = 0; a < 3; a++)
            begin
                wr_ent.origin[a] = pt_reg[a];
                wr_ent.delta[a]  = '0;
            end
        end
    end

    assign ram_we = ((state_reg == S_APPEND) && !drop && move_add) ||
                    ((state_reg == S_HOLD) && hold_add);

    wmj_ram #(
        .WIDTH (SEG_W),
        .DEPTH (SEG_DEPTH)
    ) u_seg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (seg_used_reg[SEG_AW-1:0]),
        .wdata (wr_ent),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Segment scan. Read data holds between reads, so the selected entry
    // stays on rd_ent for the whole evaluation.
    // ------------------------------------------------------------------
    logic [SEG_AW:0] idx_inc;
    logic            seg_hit, seg_last, seg_stop;
    logic [31:0]     seg_len, loc;
    logic            tau_div;

    assign idx_inc  = {1'b0, idx_reg} + 1'b1;
    assign seg_hit  = (t_reg >= rd_ent.t_beg) && (t_reg < rd_ent.t_fin);
    assign seg_last = (idx_inc == (SEG_AW + 1)'(seg_used_reg));
    assign seg_stop = seg_hit || seg_last;
    assign seg_len  = rd_ent.t_fin - rd_ent.t_beg;
    assign loc      = t_reg - rd_ent.t_beg;
    // Divide only when 0 <= local < T; otherwise tau is 0 or clamps to 1.
    assign tau_div  = (t_reg >= rd_ent.t_beg) && (loc < seg_len);

    // ------------------------------------------------------------------
    // Shared multiplier: one 34x34 signed product, registered
    // ------------------------------------------------------------------
    logic signed [33:0] mul_a, mul_b;
    logic [28:0]        pw_sel;
    logic [32:0]        d_sel;

    assign d_sel = rd_ent.delta[axis_reg];

    always_comb
    begin
        case (step_reg)
            2'd0:    pw_sel = tau_reg;
            2'd1:    pw_sel = t2_reg;
            2'd2:    pw_sel = t3_reg;
            default: pw_sel = t4_reg;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL:
            begin
                mul_a = $signed({5'b0, pw_sel});
                mul_b = $signed({5'b0, tau_reg});
            end
            S_AXP:
            begin
                mul_a = $signed({d_sel[32], d_sel});
                mul_b = s_reg;
            end
            S_AXV:
            begin
                mul_a = $signed({d_sel[32], d_sel});
                mul_b = s1_reg;
            end
            S_AXA:
            begin
                mul_a = $signed({d_sel[32], d_sel});
                mul_b = s2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Floor shift by 28 of the registered product.
    logic signed [39:0] prod_q;
    assign prod_q = prod_reg[67:28];

    // ------------------------------------------------------------------
    // Shared divider: restoring, one quotient bit per cycle, 64 steps,
    // divisor is always the selected segment's duration.
    // ------------------------------------------------------------------
    logic [32:0]        dv_trial;
    logic               dv_ge;
    logic [32:0]        dv_rem_step;
    logic [63:0]        dv_num_step;
    logic signed [63:0] dv_q;
    logic               dv_last;
    logic               dv_run;
    logic               dv_start;
    logic signed [63:0] dv_src;
    logic [63:0]        dv_mag;
    logic               acc_hi, acc_lo;

    assign dv_trial    = {dv_rem_reg, dv_num_reg[63]};
    assign dv_ge       = (dv_trial >= {1'b0, seg_len});
    assign dv_rem_step = dv_ge ? (dv_trial - {1'b0, seg_len}) : dv_trial;
    assign dv_num_step = {dv_num_reg[62:0], dv_ge};
    assign dv_q        = dv_neg_reg ? -$signed(dv_num_step) : $signed(dv_num_step);
    assign dv_last     = (dv_cnt_reg == 6'd63);
    assign acc_hi      = (dv_q >= ACC_LIM);
    assign acc_lo      = (dv_q <= -ACC_LIM);

    assign dv_run = (state_reg == S_TDIV) || (state_reg == S_VDIV) ||
                    (state_reg == S_A1DIV) || (state_reg == S_A2DIV);

    always_comb
    begin
        case (state_reg)
            S_TAU:   dv_src = $signed({4'b0, loc, 28'b0});
            S_AXVW:  dv_src = $signed({{8{prod_q[39]}}, prod_q, 16'b0});
            S_AXAW:  dv_src = $signed({{8{prod_q[39]}}, prod_q, 16'b0});
            S_A1DIV: dv_src = $signed({dv_q[47:0], 16'b0});
            default: dv_src = '0;
        endcase
    end

    assign dv_mag   = dv_src[63] ? 64'(-dv_src) : 64'(dv_src);
    assign dv_start = ((state_reg == S_TAU) && tau_div) ||
                      (state_reg == S_AXVW) || (state_reg == S_AXAW) ||
                      ((state_reg == S_A1DIV) && dv_last && !acc_hi && !acc_lo);

    // Polynomial terms of the minimum-jerk profile and its derivatives.
    logic signed [39:0] e1, e2, e3, e4, e5;
    logic signed [39:0] s_full, s1_full, s2_full;

    assign e1 = $signed({11'b0, tau_reg});
    assign e2 = $signed({11'b0, t2_reg});
    assign e3 = $signed({11'b0, t3_reg});
    assign e4 = $signed({11'b0, t4_reg});
    assign e5 = $signed({11'b0, t5_reg});
    assign s_full  = 40'sd10 * e3 - 40'sd15 * e4 + 40'sd6 * e5;
    assign s1_full = 40'sd30 * e2 - 40'sd60 * e3 + 40'sd30 * e4;
    assign s2_full = 40'sd60 * e1 - 40'sd180 * e2 + 40'sd120 * e3;

    logic signed [63:0] pos_sum;
    logic [31:0]        org_sel;
    assign org_sel = rd_ent.origin[axis_reg];
    assign pos_sum = $signed({{32{org_sel[31]}}, org_sel}) +
                     $signed({{24{prod_q[39]}}, prod_q});

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic axis_end;
    assign axis_end = (axis_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action_t'(action))
                        ACT_APPEND: state_next = S_APPEND;
                        ACT_EVAL:   state_next = (seg_used_reg == '0) ? S_OUT : S_RD;
                        default:    state_next = S_OUT;
                    endcase
                end
            end
            S_APPEND: state_next = drop ? S_OUT : S_HOLD;
            S_HOLD:   state_next = S_OUT;
            S_RD:     state_next = S_CMP;
            S_CMP:
            begin
                if (seg_stop)
                    state_next = rd_ent.is_move ? S_TAU : S_OUT;
                else
                    state_next = S_RD;
            end
            S_TAU:    state_next = tau_div ? S_TDIV : S_MUL;
            S_TDIV:   state_next = dv_last ? S_MUL : S_TDIV;
            S_MUL:    state_next = S_MULW;
            S_MULW:   state_next = (step_reg == 2'd3) ? S_POLY : S_MUL;
            S_POLY:   state_next = S_AXP;
            S_AXP:    state_next = S_AXPW;
            S_AXPW:   state_next = S_AXV;
            S_AXV:    state_next = S_AXVW;
            S_AXVW:   state_next = S_VDIV;
            S_VDIV:   state_next = dv_last ? S_AXA : S_VDIV;
            S_AXA:    state_next = S_AXAW;
            S_AXAW:   state_next = S_A1DIV;
            S_A1DIV:
            begin
                if (dv_last)
                begin
                    if (acc_hi || acc_lo)
                        state_next = axis_end ? S_OUT : S_AXP;
                    else
                        state_next = S_A2DIV;
                end
            end
            S_A2DIV:
            begin
                if (dv_last)
                    state_next = axis_end ? S_OUT : S_AXP;
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Table bookkeeping and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_used_reg <= '0;
            way_seen_reg <= 1'b0;
            cursor_reg   <= '0;
            for (int a = 0; a < 3; a++)
            begin
                prev_reg[a]  <= '0;
                first_reg[a] <= '0;
            end
            idx_reg    <= '0;
            step_reg   <= '0;
            axis_reg   <= '0;
            dv_cnt_reg <= '0;
        end
        else
        begin
            if (dv_start)
                dv_cnt_reg <= '0;
            else if (dv_run)
                dv_cnt_reg <= dv_cnt_reg + 6'd1;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg <= '0;
                        if (action_t'(action) == ACT_CLEAR)
                        begin
                            seg_used_reg <= '0;
                            way_seen_reg <= 1'b0;
                            cursor_reg   <= '0;
                            for (int a = 0; a < 3; a++)
                            begin
                                prev_reg[a]  <= '0;
                                first_reg[a] <= '0;
                            end
                        end
                    end
                end
                S_APPEND:
                begin
                    // Drop the whole append when the table cannot take it.
                    if (!drop)
                    begin
                        if (!way_seen_reg)
                        begin
                            for (int a = 0; a < 3; a++)
                                first_reg[a] <= pt_reg[a];
                        end
                        else
                        begin
                            if (move_add)
                                seg_used_reg <= seg_used_reg + 1'b1;
                            cursor_reg <= arrive_reg;
                        end
                    end
                end
                S_HOLD:
                begin
                    if (hold_add)
                    begin
                        seg_used_reg <= seg_used_reg + 1'b1;
                        cursor_reg   <= hold_end;
                    end
                    for (int a = 0; a < 3; a++)
                        prev_reg[a] <= pt_reg[a];
                    way_seen_reg <= 1'b1;
                end
                S_CMP:
                begin
                    if (!seg_stop)
                        idx_reg <= idx_inc[SEG_AW-1:0];
                end
                S_TAU:
                    step_reg <= '0;
                S_MULW:
                    step_reg <= step_reg + 2'd1;
                S_POLY:
                    axis_reg <= '0;
                S_A1DIV:
                begin
                    if (dv_last && (acc_hi || acc_lo))
                        axis_reg <= axis_reg + 2'd1;
                end
                S_A2DIV:
                begin
                    if (dv_last)
                        axis_reg <= axis_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath: transaction capture, shared units and results.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (dv_start)
        begin
            dv_rem_reg <= '0;
            dv_num_reg <= dv_mag;
            dv_neg_reg <= dv_src[63];
        end
        else if (dv_run)
        begin
            dv_rem_reg <= dv_rem_step[31:0];
            dv_num_reg <= dv_num_step;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    t_reg      <= sample_time;
                    arrive_reg <= arrive_time;
                    dwell_reg  <= dwell_time;
                    pt_reg[0]  <= way_x;
                    pt_reg[1]  <= way_y;
                    pt_reg[2]  <= way_z;
                    status_reg <= 1'b0;
                    done_reg   <= 1'b0;
                    for (int a = 0; a < 3; a++)
                    begin
                        pos_reg[a] <= '0;
                        vel_reg[a] <= '0;
                        acc_reg[a] <= '0;
                    end
                    if (action_t'(action) == ACT_EVAL)
                    begin
                        done_reg <= way_seen_reg && (sample_time >= cursor_reg);
                        // Empty table after waypoints: hold at the first one.
                        if ((seg_used_reg == '0) && way_seen_reg)
                        begin
                            for (int a = 0; a < 3; a++)
                                pos_reg[a] <= first_reg[a];
                        end
                    end
                end
            end
            S_APPEND:
            begin
                if (drop)
                    status_reg <= 1'b1;
            end
            S_CMP:
            begin
                if (seg_stop && !rd_ent.is_move)
                begin
                    for (int a = 0; a < 3; a++)
                        pos_reg[a] <= rd_ent.origin[a];
                end
            end
            S_TAU:
                tau_reg <= (t_reg < rd_ent.t_beg) ? '0 : TAU_ONE;
            S_TDIV:
            begin
                if (dv_last)
                    tau_reg <= dv_num_step[28:0];
            end
            S_MULW:
            begin
                case (step_reg)
                    2'd0:    t2_reg <= prod_reg[56:28];
                    2'd1:    t3_reg <= prod_reg[56:28];
                    2'd2:    t4_reg <= prod_reg[56:28];
                    default: t5_reg <= prod_reg[56:28];
                endcase
            end
            S_POLY:
            begin
                s_reg  <= s_full[33:0];
                s1_reg <= s1_full[33:0];
                s2_reg <= s2_full[33:0];
            end
            S_AXPW:
                pos_reg[axis_reg] <= sat32(pos_sum);
            S_VDIV:
            begin
                if (dv_last)
                    vel_reg[axis_reg] <= sat32(dv_q);
            end
            S_A1DIV:
            begin
                if (dv_last)
                begin
                    if (acc_hi)
                        acc_reg[axis_reg] <= 32'sh7FFF_FFFF;
                    else if (acc_lo)
                        acc_reg[axis_reg] <= 32'sh8000_0000;
                end
            end
            S_A2DIV:
            begin
                if (dv_last)
                    acc_reg[axis_reg] <= sat32(dv_q);
            end
            default:
            begin
            end
        endcase
    end

    assign out_pos_x = pos_reg[0];
    assign out_pos_y = pos_reg[1];
    assign out_pos_z = pos_reg[2];
    assign out_vel_x = vel_reg[0];
    assign out_vel_y = vel_reg[1];
    assign out_vel_z = vel_reg[2];
    assign out_acc_x = acc_reg[0];
    assign out_acc_y = acc_reg[1];
    assign out_acc_z = acc_reg[2];
    assign done_flag = done_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> (!strobe && !busy))
        else $error("result strobe not followed by idle");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seg_used_reg <= (SEG_CW)'(SEG_DEPTH))
        else $error("segment count beyond table depth");

    a_empty_history: assert property (@(posedge clk) disable iff (!rst_n)
        !way_seen_reg |-> (seg_used_reg == '0))
        else $error("segments present without any waypoint");

    a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status) |-> (!done_flag && out_pos_x == 32'sd0))
        else $error("dropped append carried nonzero result fields");
`endif

endmodule
